// ----- design/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types, widths and codes of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int CMD_W     = 2;
  localparam int START_W   = 8;
  localparam int SIZE_W    = 18;
  localparam int BS_W      = 11;
  localparam int CNT_W     = 9;
  localparam int ALLOC_W   = 19;
  localparam int SLACK_W   = 10;
  localparam int REM_W     = 10;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_BLOCKS_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [BS_W-1:0] MAX_BLOCK_SIZE = 11'd1024;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXT_FRAG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INT_FRAG = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_EXT,
    OP_INT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [SIZE_W-1:0]  blocks_needed;
    logic [ALLOC_W-1:0] allocated_space_kb;
    logic [SLACK_W-1:0] internal_slack_kb;
    logic [CNT_W-1:0]   free_block_total;
    logic [CNT_W-1:0]   largest_free_run;
    logic               external_fragmented;
  } res_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_RANGE,
    BK_SCAN,
    BK_MARK,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ----- design/cba_ram.sv -----
// ----------------------------------------------------------------------------
// cba_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/cba_div.sv -----
// ----------------------------------------------------------------------------
// cba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_div import cba_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SIZE_W-1:0] dividend,
  input  wire logic [BS_W-1:0]   divisor,
  output logic                   done,
  output logic      [SIZE_W-1:0] quotient,
  output logic      [REM_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(SIZE_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [BS_W-1:0]   dvs_r, dvs_nxt;
  logic [BS_W-1:0]   trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[SIZE_W-1]};
    ge       = (trial >= dvs_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(SIZE_W - 1);
    end else if (busy_r) begin
      // below the divisor the trial value fits the remainder width
      rem_nxt = ge ? REM_W'(trial - dvs_r) : trial[REM_W-1:0];
      quo_nxt = {quo_r[SIZE_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- design/cba_queue.sv -----
// ----------------------------------------------------------------------------
// cba_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_queue import cba_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      head_item
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0]  wp_r, wp_nxt;
  logic [QP_W-1:0]  rp_r, rp_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QP_W'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + QP_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  assign head_item = slot_r[rp_r];

endmodule

`default_nettype wire

// ----- design/cba_front.sv -----
// ----------------------------------------------------------------------------
// cba_front
// Input stage: accepts transactions, decodes the command, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_front import cba_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clearing,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   in_command,
  input  wire logic [START_W-1:0] in_start_block,
  input  wire logic [SIZE_W-1:0]  in_file_size_kb,
  output logic                    q_push,
  output item_t                   q_item,
  input  wire logic               q_full
);

  logic  fr_valid_r, fr_valid_nxt;
  item_t fr_item_r;
  item_t dec_item;
  logic  take;

  always_comb begin
    dec_item.start = in_start_block;
    dec_item.size  = in_file_size_kb;
    case (in_command)
      CMD_ALLOC:    dec_item.op = OP_ALLOC;
      CMD_EXT_FRAG: dec_item.op = OP_EXT;
      CMD_INT_FRAG: dec_item.op = OP_INT;
      default:      dec_item.op = OP_NONE;
    endcase
  end

  assign q_push   = fr_valid_r && !q_full;
  assign in_ready = !clearing && (!fr_valid_r || !q_full);
  assign take     = in_valid && in_ready;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= dec_item;
    end
  end

  assign q_item = fr_item_r;

endmodule

`default_nettype wire

// ----- design/cba_back.sv -----
// ----------------------------------------------------------------------------
// cba_back
// Execution sequencer: map clearing, size division, map scan and marking.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_back import cba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [BS_W-1:0]  eff_bs,
  input  wire logic [CNT_W-1:0] eff_cnt,
  output logic                  clearing,
  input  wire logic             q_empty,
  input  wire item_t            q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output res_t                  out_res
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int PTR_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(NUM_BLOCKS - 1);

  back_state_t       st_r, st_nxt;
  item_t             item_r, item_nxt;
  res_t              res_r, res_nxt;
  res_t              ores_r, ores_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  end_r, end_nxt;
  logic              hit_r, hit_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  run_inc;

  logic              div_start, div_done;
  logic [SIZE_W-1:0] div_quo;
  logic [REM_W-1:0]  div_rem;
  logic              rem_nz;
  logic [SIZE_W-1:0] need;
  logic [ALLOC_W-1:0] alloc_kb;
  logic [SLACK_W-1:0] slack_kb;
  logic [ALLOC_W-1:0] range_end;
  logic              issue;

  logic              ram_we, ram_wdata, ram_rdata;

  cba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_item.size),
    .divisor   (eff_bs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  cba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ptr_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // allocated space is the size rounded up to a block multiple
  assign rem_nz    = (div_rem != '0);
  assign need      = div_quo + SIZE_W'(rem_nz);
  assign alloc_kb  = ALLOC_W'(item_r.size) - ALLOC_W'(div_rem)
                   + (rem_nz ? ALLOC_W'(eff_bs) : '0);
  assign slack_kb  = rem_nz ? SLACK_W'(eff_bs - BS_W'(div_rem)) : '0;
  assign range_end = ALLOC_W'(item_r.start) + ALLOC_W'(res_r.blocks_needed);
  assign issue     = (ptr_r < end_r);
  assign run_inc   = run_r + CNT_W'(1);

  always_comb begin
    st_nxt     = st_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    ores_nxt   = ores_r;
    ovalid_nxt = ovalid_r;
    ptr_nxt    = ptr_r;
    end_nxt    = end_r;
    hit_nxt    = hit_r;
    rd_v_nxt   = 1'b0;
    run_nxt    = run_r;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = 1'b0;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (st_r)
      BK_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt = '0;
          st_nxt  = BK_IDLE;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          res_nxt  = '0;
          hit_nxt  = 1'b0;
          run_nxt  = '0;
          case (q_item.op)
            OP_ALLOC, OP_INT: begin
              div_start = 1'b1;
              st_nxt    = BK_DIV;
            end
            OP_EXT: begin
              ptr_nxt = '0;
              end_nxt = PTR_W'(eff_cnt);
              st_nxt  = BK_SCAN;
            end
            default: st_nxt = BK_DONE;
          endcase
        end
      end
      BK_DIV: begin
        if (div_done) begin
          res_nxt.blocks_needed      = need;
          res_nxt.allocated_space_kb = alloc_kb;
          res_nxt.internal_slack_kb  = slack_kb;
          if (item_r.op == OP_ALLOC && need != '0) begin
            st_nxt = BK_RANGE;
          end else begin
            st_nxt = BK_DONE;
          end
        end
      end
      BK_RANGE: begin
        if (range_end > ALLOC_W'(eff_cnt)) begin
          res_nxt.status = 1'b1;
          st_nxt         = BK_DONE;
        end else begin
          ptr_nxt = PTR_W'(item_r.start);
          end_nxt = PTR_W'(range_end);
          st_nxt  = BK_SCAN;
        end
      end
      BK_SCAN: begin
        // read one address per cycle, data comes back in the next cycle
        rd_v_nxt = issue;
        if (issue) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (rd_v_r) begin
          if (item_r.op == OP_ALLOC) begin
            if (ram_rdata) begin
              hit_nxt = 1'b1;
            end
          end else if (!ram_rdata) begin
            res_nxt.free_block_total = res_r.free_block_total + CNT_W'(1);
            run_nxt                  = run_inc;
            if (run_inc > res_r.largest_free_run) begin
              res_nxt.largest_free_run = run_inc;
            end
          end else begin
            run_nxt = '0;
          end
        end
        if (!issue && !rd_v_r) begin
          if (item_r.op == OP_ALLOC) begin
            if (hit_r) begin
              res_nxt.status = 1'b1;
              st_nxt         = BK_DONE;
            end else begin
              ptr_nxt = PTR_W'(item_r.start);
              st_nxt  = BK_MARK;
            end
          end else begin
            res_nxt.external_fragmented = (res_r.free_block_total != '0) &&
                (res_r.largest_free_run < res_r.free_block_total);
            st_nxt = BK_DONE;
          end
        end
      end
      BK_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        if (ptr_r + PTR_W'(1) == end_r) begin
          st_nxt = BK_DONE;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
      BK_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ores_nxt   = res_r;
          st_nxt     = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_CLEAR;
      ptr_r    <= '0;
      ovalid_r <= 1'b0;
      rd_v_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ptr_r    <= ptr_nxt;
      ovalid_r <= ovalid_nxt;
      rd_v_r   <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    ores_r <= ores_nxt;
    end_r  <= end_nxt;
    hit_r  <= hit_nxt;
    run_r  <= run_nxt;
  end

  assign clearing  = (st_r == BK_CLEAR);
  assign out_valid = ovalid_r;
  assign out_res   = ores_r;

endmodule

`default_nettype wire

// ----- design/contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Contiguous block allocator over a one-bit-per-block allocation map.
// ----------------------------------------------------------------------------
// usage
//   in_*  : command transactions (valid/ready); allocate, external
//           fragmentation report or internal fragmentation report
//   out_* : one result transaction per command, held in an output register
//   cfg_* : block size and block count writes; the user must write them only
//           while the block is idle, the block itself does not enforce it
// steps in the back sequencer, per command
//   internal report : the divide in the 18-step serial divider
//   allocate        : divide, one map read per block, one map write per
//                     block; a failed range check ends right after the
//                     divide, and a taken block ends it after the scan
//   external report : one map read per block
//   unused command  : no map access, straight to the result
//   the input stage register and the command queue lie ahead of that
// throughput: one command at a time in the back sequencer; the front stage
//   and a two-entry queue keep taking commands while it works
// reset: the allocation map is swept clear, one block per cycle, over all
//   NUM_BLOCKS entries; in_ready stays low until the sweep ends
// a stalled receiver holds the result in the output register; the back
//   part waits on it while the front keeps filling the queue
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_allocator import cba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [START_W-1:0]   in_start_block,
  input  wire logic [SIZE_W-1:0]    in_file_size_kb,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_status,
  output logic      [SIZE_W-1:0]    out_blocks_needed,
  output logic      [ALLOC_W-1:0]   out_allocated_space_kb,
  output logic      [SLACK_W-1:0]   out_internal_slack_kb,
  output logic      [CNT_W-1:0]     out_free_block_total,
  output logic      [CNT_W-1:0]     out_largest_free_run,
  output logic                      out_external_fragmented,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BS_W-1:0]      cfg_wdata
);

  // block counts past the map depth saturate; the register is 9 bits wide
  localparam int CNT_CAP = (NUM_BLOCKS > 511) ? 511 : NUM_BLOCKS;

  logic [BS_W-1:0]  cfg_block_size_r;
  logic [CNT_W-1:0] cfg_block_count_r;
  logic [BS_W-1:0]  eff_bs;
  logic [CNT_W-1:0] eff_cnt;

  logic  clearing;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in_item, q_head_item;
  res_t  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_block_size_r  <= BS_W'(1);
      cfg_block_count_r <= CNT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:  cfg_block_size_r  <= cfg_wdata;
        CFG_BLOCK_COUNT: cfg_block_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero block size acts as one, sizes above the maximum are clipped
  assign eff_bs = (cfg_block_size_r == '0) ? BS_W'(1) :
                  (cfg_block_size_r > MAX_BLOCK_SIZE) ? MAX_BLOCK_SIZE :
                  cfg_block_size_r;
  assign eff_cnt = (cfg_block_count_r > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) :
                   cfg_block_count_r;

  // front: accept and decode
  cba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .clearing        (clearing),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_start_block  (in_start_block),
    .in_file_size_kb (in_file_size_kb),
    .q_push          (q_push),
    .q_item          (q_in_item),
    .q_full          (q_full)
  );

  // command queue between front and back
  cba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head_item)
  );

  // back: divide, scan and mark the map, drive the result register
  cba_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_bs    (eff_bs),
    .eff_cnt   (eff_cnt),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_item    (q_head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status              = res.status;
  assign out_blocks_needed       = res.blocks_needed;
  assign out_allocated_space_kb  = res.allocated_space_kb;
  assign out_internal_slack_kb   = res.internal_slack_kb;
  assign out_free_block_total    = res.free_block_total;
  assign out_largest_free_run    = res.largest_free_run;
  assign out_external_fragmented = res.external_fragmented;

  // no transaction may enter while the map is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("command accepted during map clear");

  // a failed allocation always asked for at least one block
  a_fail_has_need: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_blocks_needed != '0))
    else $error("allocation failure with zero blocks needed");

  // the longest free run never exceeds the free total
  a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_largest_free_run <= out_free_block_total))
    else $error("longest free run above free total");

  // fragmentation flag only with free blocks outside the longest run
  a_frag_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_external_fragmented) |->
      (out_largest_free_run < out_free_block_total))
    else $error("fragmentation flag without split free space");

endmodule

`default_nettype wire

// ----- verif/cba_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cba_checker
// Watches the command, result and configuration ports of the allocator. It
// keeps its own copy of the block size, the block count and the allocation
// map. It predicts one result per accepted command and compares each
// returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module cba_checker import cba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [START_W-1:0]   in_start_block,
  input  logic [SIZE_W-1:0]    in_file_size_kb,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_status,
  input  logic [SIZE_W-1:0]    out_blocks_needed,
  input  logic [ALLOC_W-1:0]   out_allocated_space_kb,
  input  logic [SLACK_W-1:0]   out_internal_slack_kb,
  input  logic [CNT_W-1:0]     out_free_block_total,
  input  logic [CNT_W-1:0]     out_largest_free_run,
  input  logic                 out_external_fragmented,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BS_W-1:0]      cfg_wdata,
  output int unsigned          error_count,
  output int unsigned          pending
);

  logic [BS_W-1:0]  block_size_reg;
  logic [CNT_W-1:0] block_count_reg;
  logic             block_taken [NUM_BLOCKS];
  res_t             expected_results [$];
  res_t             want;

  initial begin
    error_count = 0;
    pending     = 0;
  end

  // works out the result of one command and updates the map for an allocate
  function automatic res_t predict_result(input logic [CMD_W-1:0]   cmd,
                                          input logic [START_W-1:0] first,
                                          input logic [SIZE_W-1:0]  size);
    res_t        r;
    int unsigned bs, cnt, need, stop, space, total, best, run;
    logic        clash;
    r     = '0;
    bs    = (block_size_reg == '0) ? 1 :
            (block_size_reg > MAX_BLOCK_SIZE) ? MAX_BLOCK_SIZE : block_size_reg;
    cnt   = (block_count_reg > NUM_BLOCKS) ? NUM_BLOCKS : block_count_reg;
    need  = (size + bs - 1) / bs;
    space = need * bs;
    case (cmd)
      CMD_ALLOC, CMD_INT_FRAG: begin
        r.blocks_needed      = SIZE_W'(need);
        r.allocated_space_kb = ALLOC_W'(space);
        r.internal_slack_kb  = SLACK_W'(space - size);
        if (cmd == CMD_ALLOC && need != 0) begin
          stop = first + need;
          if (stop > cnt) begin
            r.status = 1'b1;
          end else begin
            clash = 1'b0;
            for (int i = first; i < stop; i++) clash |= block_taken[i];
            if (clash) r.status = 1'b1;
            else for (int i = first; i < stop; i++) block_taken[i] = 1'b1;
          end
        end
      end
      CMD_EXT_FRAG: begin
        total = 0;
        best  = 0;
        run   = 0;
        for (int i = 0; i < cnt; i++) begin
          if (!block_taken[i]) begin
            total++;
            run++;
            if (run > best) best = run;
          end else begin
            run = 0;
          end
        end
        r.free_block_total    = CNT_W'(total);
        r.largest_free_run    = CNT_W'(best);
        r.external_fragmented = (total > 0 && best < total);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      block_size_reg  = BS_W'(1);
      block_count_reg = CNT_W'(256);
      foreach (block_taken[i]) block_taken[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_SIZE:  block_size_reg  = cfg_wdata;
          CFG_BLOCK_COUNT: block_count_reg = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_result(in_command, in_start_block,
                                                  in_file_size_kb));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("blocks_needed", want.blocks_needed, out_blocks_needed);
          compare_field("allocated_space_kb", want.allocated_space_kb,
                        out_allocated_space_kb);
          compare_field("internal_slack_kb", want.internal_slack_kb,
                        out_internal_slack_kb);
          compare_field("free_block_total", want.free_block_total,
                        out_free_block_total);
          compare_field("largest_free_run", want.largest_free_run,
                        out_largest_free_run);
          compare_field("external_fragmented", want.external_fragmented,
                        out_external_fragmented);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the contiguous block allocator through directed corner cases and
// then through random command mixes under several block size and block
// count settings. Both sides idle and stall at random. A checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------

module testbench;
  import cba_pkg::*;

  // the fourth command code has no meaning, the block answers with zeros
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES  = 600;   // longer than the slowest allocate
  localparam int PHASE_ITEMS    = 222;
  localparam int NUM_PHASES     = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [CMD_W-1:0]     in_command      = '0;
  logic [START_W-1:0]   in_start_block  = '0;
  logic [SIZE_W-1:0]    in_file_size_kb = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BS_W-1:0]      cfg_wdata = '0;

  wire                  in_ready;
  wire                  out_valid;
  wire                  out_status;
  wire [SIZE_W-1:0]     out_blocks_needed;
  wire [ALLOC_W-1:0]    out_allocated_space_kb;
  wire [SLACK_W-1:0]    out_internal_slack_kb;
  wire [CNT_W-1:0]      out_free_block_total;
  wire [CNT_W-1:0]      out_largest_free_run;
  wire                  out_external_fragmented;

  int unsigned error_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  // idling switches, cleared for the fourth and the closing phases
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;

  // effective block size and count, only used to shape random commands
  int unsigned eff_bs  = 1;
  int unsigned eff_cnt = 256;

  // per-phase settings for the random part, extremes included
  int unsigned phase_bs  [NUM_PHASES] = '{1, 3, 0, 64, 1024, 2047, 700, 5};
  int unsigned phase_cnt [NUM_PHASES] = '{24, 48, 96, 128, 160, 200, 511, 256};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contiguous_block_allocator u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_start_block          (in_start_block),
    .in_file_size_kb         (in_file_size_kb),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_blocks_needed       (out_blocks_needed),
    .out_allocated_space_kb  (out_allocated_space_kb),
    .out_internal_slack_kb   (out_internal_slack_kb),
    .out_free_block_total    (out_free_block_total),
    .out_largest_free_run    (out_largest_free_run),
    .out_external_fragmented (out_external_fragmented),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  cba_checker u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_start_block          (in_start_block),
    .in_file_size_kb         (in_file_size_kb),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_blocks_needed       (out_blocks_needed),
    .out_allocated_space_kb  (out_allocated_space_kb),
    .out_internal_slack_kb   (out_internal_slack_kb),
    .out_free_block_total    (out_free_block_total),
    .out_largest_free_run    (out_largest_free_run),
    .out_external_fragmented (out_external_fragmented),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .error_count             (error_count),
    .pending                 (pending)
  );

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[contiguous_block_allocator] ERROR");
      $finish;
    end
  end

  // result side: ready in random bursts, broken by random stalls
  initial begin
    @(posedge rst_n);
    forever begin
      if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // one command transaction; valid stays up when the next one follows at once
  task automatic send_cmd(input logic [CMD_W-1:0]   cmd,
                          input logic [START_W-1:0] first,
                          input logic [SIZE_W-1:0]  size);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_start_block  <= first;
    in_file_size_kb <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, one per cycle, only while the block is idle
  task automatic write_config(input int unsigned bs, input int unsigned cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_wdata <= BS_W'(bs);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_wdata <= BS_W'(cnt);
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_bs  = (bs == 0) ? 1 : (bs > 1024) ? 1024 : bs;
    eff_cnt = ((cnt % 512) > 256) ? 256 : (cnt % 512);
  endtask

  // allocations, mostly with small sizes and starts up to just past the current
  // block count, plus reports, the unused code and some fully random fields
  task automatic send_random_item();
    int unsigned        pick, n, last_start;
    logic [CMD_W-1:0]   cmd;
    logic [START_W-1:0] first;
    logic [SIZE_W-1:0]  size;
    pick  = $urandom_range(0, 99);
    first = START_W'($urandom_range(0, 255));
    size  = SIZE_W'($urandom_range(0, 262143));
    if (pick < 45) begin
      cmd        = CMD_ALLOC;
      last_start = (eff_cnt + 2 > 255) ? 255 : eff_cnt + 2;
      if ($urandom_range(0, 9) != 0) begin
        first = START_W'($urandom_range(0, last_start));
        n     = $urandom_range(0, 5);
        size  = SIZE_W'((n == 0) ? 0 :
                        (n - 1) * eff_bs + $urandom_range(1, eff_bs));
      end
    end else if (pick < 70) begin
      cmd = CMD_EXT_FRAG;
    end else if (pick < 95) begin
      cmd = CMD_INT_FRAG;
      if ($urandom_range(0, 1) == 1) size = SIZE_W'($urandom_range(0, 4 * eff_bs));
    end else begin
      cmd = CMD_RESERVED;
    end
    send_cmd(cmd, first, size);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: block size 1, block count 256, empty map
    send_cmd(CMD_EXT_FRAG, 8'hff, 18'h3ffff);
    send_cmd(CMD_INT_FRAG, 8'h00, 18'd0);
    send_cmd(CMD_INT_FRAG, 8'h00, 18'h3ffff);
    send_cmd(CMD_INT_FRAG, 8'h00, 18'd1);
    send_cmd(CMD_RESERVED, 8'hff, 18'h3ffff);
    send_cmd(CMD_RESERVED, 8'h00, 18'd0);
    send_cmd(CMD_ALLOC, 8'd255, 18'd0);        // zero size, nothing marked
    send_cmd(CMD_ALLOC, 8'd255, 18'd1);        // last block
    send_cmd(CMD_ALLOC, 8'd254, 18'd2);        // overlaps the last block
    send_cmd(CMD_ALLOC, 8'd0, 18'h3ffff);      // runs past the block count
    send_cmd(CMD_ALLOC, 8'd10, 18'd3);
    send_cmd(CMD_ALLOC, 8'd12, 18'd1);         // already taken
    send_cmd(CMD_EXT_FRAG, 8'd0, 18'd0);       // map now fragmented

    // zero block size and zero block count
    drain();
    write_config(0, 0);
    send_cmd(CMD_ALLOC, 8'd0, 18'd1);
    send_cmd(CMD_ALLOC, 8'd0, 18'd0);
    send_cmd(CMD_EXT_FRAG, 8'd0, 18'd0);
    send_cmd(CMD_INT_FRAG, 8'd0, 18'd5);

    // both registers above range, saturated
    drain();
    write_config(2047, 511);
    send_cmd(CMD_INT_FRAG, 8'd0, 18'h3ffff);   // allocated space wider than size
    send_cmd(CMD_INT_FRAG, 8'd0, 18'd1);       // largest slack
    send_cmd(CMD_ALLOC, 8'd20, 18'd1025);
    send_cmd(CMD_ALLOC, 8'd200, 18'h3ffff);
    send_cmd(CMD_EXT_FRAG, 8'd0, 18'd0);

    // largest legal block size, a single block
    drain();
    write_config(1024, 1);
    send_cmd(CMD_ALLOC, 8'd0, 18'd1);
    send_cmd(CMD_ALLOC, 8'd0, 18'd1);
    send_cmd(CMD_EXT_FRAG, 8'd0, 18'd0);

    // random phases; the fourth and the last two run without idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_config(phase_bs[ph], phase_cnt[ph]);
      tx_gaps_on   = (ph % 4 != 3) && (ph < NUM_PHASES - 2);
      rx_stalls_on = tx_gaps_on;
      repeat (PHASE_ITEMS) send_random_item();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("[contiguous_block_allocator] OK");
    end else begin
      $display("[contiguous_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
